@@ src/quaternion_to_euler_angles_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angles block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qte assertion failed: same-cycle check");
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte assertion failed: next-cycle check");
`else
`define QTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, constants and payload types shared by the Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int Q14_W    = 16;
  localparam int PROD_W   = 32;
  localparam int ARG_W    = 34;
  localparam int SQ_BITS  = 31;
  localparam int SQ_VW    = 63;
  localparam int CW       = 45;
  localparam int ANG_W    = 34;
  localparam int SHIFT_W  = 6;
  localparam int NORM_TOP = 40;
  localparam int TAB_LEN  = 24;
  localparam int CENTI_W  = 52;

  // atan(2^-i) in binary angle units, 2^32 per turn.
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  localparam logic signed [ANG_W-1:0]   QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ARG_W-1:0]   DEGEN_N      = 34'sd269;
  localparam logic signed [CENTI_W-1:0] CENTI_SCALE  = 52'sd36000;
  localparam logic signed [CENTI_W-1:0] HALF_UNIT    = 52'sd2147483648;

  typedef struct packed {
    logic degen;
    logic clamp;
    logic neg;
  } tag_t;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANG_W-1:0] ang;
    logic                    zero;
    tag_t                    tag;
  } crd_t;

  typedef struct packed {
    logic signed [ARG_W-1:0] roll_y;
    logic signed [ARG_W-1:0] roll_x;
    logic signed [ARG_W-1:0] yaw_y;
    logic signed [ARG_W-1:0] yaw_x;
    logic [SQ_BITS-1:0]      ss;
    tag_t                    tag;
  } side_t;

  typedef struct packed {
    logic [SQ_VW-1:0]   rem;
    logic [SQ_BITS-1:0] root;
    side_t              side;
  } sq_t;

endpackage

@@ src/qte_in_if.sv @@
// ----------------------------------------------------------------------------
// qte_in_if
// Quaternion input channel: valid/ready handshake with four components.
// ----------------------------------------------------------------------------
interface qte_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

@@ src/qte_out_if.sv @@
// ----------------------------------------------------------------------------
// qte_out_if
// Euler angle result channel: valid/ready handshake with angles and flags.
// ----------------------------------------------------------------------------
interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_centideg;
  logic signed [14:0] pitch_centideg;
  logic signed [15:0] yaw_centideg;
  logic               degenerate;
  logic               pitch_clamped;

  modport source (output valid, roll_centideg, pitch_centideg, yaw_centideg,
                  degenerate, pitch_clamped, input ready);
  modport sink   (input valid, roll_centideg, pitch_centideg, yaw_centideg,
                  degenerate, pitch_clamped, output ready);
endinterface

@@ src/qte_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One bit of a pipelined restoring square root; carries side data along.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  qte_pkg::sq_t  d_in,
  output qte_pkg::sq_t  d_out
);

  logic [qte_pkg::SQ_VW-1:0] trial;
  qte_pkg::sq_t              sq_nxt;
  qte_pkg::sq_t              sq_r;

  // The remainder holds v - root^2; setting this bit costs 2*root*2^BIT + 4^BIT.
  always_comb begin
    trial  = (qte_pkg::SQ_VW'(d_in.root) << (BIT + 1))
           + (qte_pkg::SQ_VW'(1) << (2 * BIT));
    sq_nxt = d_in;
    if (d_in.rem >= trial) begin
      sq_nxt.rem  = d_in.rem - trial;
      sq_nxt.root = d_in.root | (qte_pkg::SQ_BITS'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign d_out = sq_r;

endmodule

@@ src/qte_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring rotation step of the arctangent chain.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  qte_pkg::crd_t  c_in,
  output qte_pkg::crd_t  c_out
);

  logic signed [qte_pkg::CW-1:0] dx;
  logic signed [qte_pkg::CW-1:0] dy;
  qte_pkg::crd_t                 c_nxt;
  qte_pkg::crd_t                 c_r;

  always_comb begin
    dx    = c_in.y >>> STEP;
    dy    = c_in.x >>> STEP;
    c_nxt = c_in;
    if (!c_in.y[qte_pkg::CW-1]) begin
      c_nxt.x   = c_in.x + dx;
      c_nxt.y   = c_in.y - dy;
      c_nxt.ang = c_in.ang + qte_pkg::ATAN_TAB[STEP];
    end else begin
      c_nxt.x   = c_in.x - dx;
      c_nxt.y   = c_in.y + dy;
      c_nxt.ang = c_in.ang - qte_pkg::ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

@@ src/qte_atan2.sv @@
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined four-quadrant arctangent with conversion to centidegrees.
// ----------------------------------------------------------------------------
module qte_atan2 #(
  parameter int ITERS = 16,
  parameter int OUT_W = 16,
  parameter int LIMIT = 18000
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [qte_pkg::ARG_W-1:0]   arg_y,
  input  logic signed [qte_pkg::ARG_W-1:0]   arg_x,
  input  qte_pkg::tag_t                      tag_in,
  output logic signed [OUT_W-1:0]            angle,
  output qte_pkg::tag_t                      tag_out
);

  localparam logic signed [qte_pkg::CENTI_W-1:0] LIM_P = qte_pkg::CENTI_W'(LIMIT);
  localparam logic signed [qte_pkg::CENTI_W-1:0] LIM_N = -LIM_P;

  // Normalize: find the doubling count that lifts the top bit of the larger magnitude to bit 40.
  logic [qte_pkg::ARG_W-1:0]         abs_x;
  logic [qte_pkg::ARG_W-1:0]         abs_y;
  logic [qte_pkg::ARG_W-1:0]         mag;
  logic [qte_pkg::SHIFT_W-1:0]       msb;
  logic signed [qte_pkg::ARG_W-1:0]  nx_r;
  logic signed [qte_pkg::ARG_W-1:0]  ny_r;
  logic [qte_pkg::SHIFT_W-1:0]       k_r;
  logic                              zero_r;
  qte_pkg::tag_t                     ntag_r;

  always_comb begin
    abs_x = arg_x[qte_pkg::ARG_W-1] ? qte_pkg::ARG_W'(-arg_x) : qte_pkg::ARG_W'(arg_x);
    abs_y = arg_y[qte_pkg::ARG_W-1] ? qte_pkg::ARG_W'(-arg_y) : qte_pkg::ARG_W'(arg_y);
    mag   = abs_x | abs_y;
    msb   = '0;
    for (int i = 0; i < qte_pkg::ARG_W; i++) begin
      if (mag[i]) begin
        msb = qte_pkg::SHIFT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= arg_x;
      ny_r   <= arg_y;
      k_r    <= qte_pkg::SHIFT_W'(qte_pkg::NORM_TOP) - msb;
      zero_r <= (mag == '0);
      ntag_r <= tag_in;
    end
  end

  // Shift up and fold the left half plane into the right by a quarter turn.
  logic signed [qte_pkg::CW-1:0] xs;
  logic signed [qte_pkg::CW-1:0] ys;
  qte_pkg::crd_t                 c0_nxt;
  qte_pkg::crd_t                 c0_r;
  qte_pkg::crd_t                 chain [ITERS+1];

  always_comb begin
    xs          = qte_pkg::CW'(nx_r) <<< k_r;
    ys          = qte_pkg::CW'(ny_r) <<< k_r;
    c0_nxt.x    = xs;
    c0_nxt.y    = ys;
    c0_nxt.ang  = '0;
    c0_nxt.zero = zero_r;
    c0_nxt.tag  = ntag_r;
    if (xs[qte_pkg::CW-1]) begin
      if (!ys[qte_pkg::CW-1]) begin
        c0_nxt.x   = ys;
        c0_nxt.y   = -xs;
        c0_nxt.ang = qte_pkg::QUARTER_TURN;
      end else begin
        c0_nxt.x   = -ys;
        c0_nxt.y   = xs;
        c0_nxt.ang = -qte_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= c0_nxt;
    end
  end

  assign chain[0] = c0_r;

  for (genvar g = 0; g < ITERS; g++) begin : g_step
    qte_cordic_cell #(.STEP(g)) u_cell (
      .clk   (clk),
      .en    (en),
      .c_in  (chain[g]),
      .c_out (chain[g+1])
    );
  end

  // Binary angle to centidegrees, rounded to nearest, saturated; 0 if degen/zero, limit if clamp
  logic signed [qte_pkg::CENTI_W-1:0] prod_r;
  logic                               zero2_r;
  qte_pkg::tag_t                      tag2_r;
  logic signed [qte_pkg::CENTI_W-1:0] quo;
  logic signed [qte_pkg::CENTI_W-1:0] sat;
  logic signed [OUT_W-1:0]            angle_nxt;
  logic signed [OUT_W-1:0]            angle_r;
  qte_pkg::tag_t                      tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= qte_pkg::CENTI_W'(chain[ITERS].ang) * qte_pkg::CENTI_SCALE
               + qte_pkg::HALF_UNIT;
      zero2_r <= chain[ITERS].zero;
      tag2_r  <= chain[ITERS].tag;
    end
  end

  always_comb begin
    quo = prod_r >>> 32;
    if (quo > LIM_P) begin
      sat = LIM_P;
    end else if (quo < LIM_N) begin
      sat = LIM_N;
    end else begin
      sat = quo;
    end
    priority if (tag2_r.degen || zero2_r) begin
      angle_nxt = '0;
    end else if (tag2_r.clamp) begin
      angle_nxt = tag2_r.neg ? OUT_W'(LIM_N) : OUT_W'(LIM_P);
    end else begin
      angle_nxt = OUT_W'(sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
      tag_r   <= tag2_r;
    end
  end

  assign angle   = angle_r;
  assign tag_out = tag_r;

endmodule

@@ src/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Throughput: one quaternion per cycle while the result beat is not stalled,
// set by the 31-cell square root chain
// and the per-iteration CORDIC cells, all fully pipelined.
// A stalled result beat holds the whole pipeline. Reset clears all valid bits.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_assert.svh"

module quaternion_to_euler_angles #(
  parameter int COMPONENT_WIDTH  = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  qte_in_if.sink          in_stream,
  qte_out_if.source       out_stream
);

  localparam int LAT = 5 + qte_pkg::SQ_BITS + 1 + ANGLE_ITERATIONS + 4;

  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv             = !vld_r[LAT-1] || out_stream.ready;
  assign in_stream.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_stream.valid};
    end
  end

  // Bring each component to Q2.14.
  logic [COMPONENT_WIDTH-1:0]          comp_in [4];
  logic signed [qte_pkg::Q14_W-1:0]    q_nxt [4];
  logic signed [qte_pkg::Q14_W-1:0]    q_r [4];

  assign comp_in[0] = in_stream.quat_w;
  assign comp_in[1] = in_stream.quat_x;
  assign comp_in[2] = in_stream.quat_y;
  assign comp_in[3] = in_stream.quat_z;

  for (genvar g = 0; g < 4; g++) begin : g_q14
    if (COMPONENT_WIDTH >= qte_pkg::Q14_W) begin : g_wide
      assign q_nxt[g] = comp_in[g][COMPONENT_WIDTH-1 -: qte_pkg::Q14_W];
    end else begin : g_narrow
      assign q_nxt[g] = {comp_in[g], {(qte_pkg::Q14_W-COMPONENT_WIDTH){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= q_nxt;
    end
  end

  // Products.
  logic signed [qte_pkg::PROD_W-1:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r, p_wx_r;
  logic signed [qte_pkg::PROD_W-1:0] p_yz_r, p_wy_r, p_zx_r, p_wz_r, p_xy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ww_r <= q_r[0] * q_r[0];
      p_xx_r <= q_r[1] * q_r[1];
      p_yy_r <= q_r[2] * q_r[2];
      p_zz_r <= q_r[3] * q_r[3];
      p_wx_r <= q_r[0] * q_r[1];
      p_yz_r <= q_r[2] * q_r[3];
      p_wy_r <= q_r[0] * q_r[2];
      p_zx_r <= q_r[3] * q_r[1];
      p_wz_r <= q_r[0] * q_r[3];
      p_xy_r <= q_r[1] * q_r[2];
    end
  end

  // Sums: squared norm and the arctangent arguments with normalization folded in.
  logic signed [qte_pkg::ARG_W-1:0] n_nxt;
  logic signed [qte_pkg::ARG_W-1:0] n_r, rolly_r, rollx_r, yawy_r, yawx_r, s_r;
  logic                             degen_r;

  assign n_nxt = qte_pkg::ARG_W'(p_ww_r) + qte_pkg::ARG_W'(p_xx_r)
               + qte_pkg::ARG_W'(p_yy_r) + qte_pkg::ARG_W'(p_zz_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r     <= n_nxt;
      rolly_r <= (qte_pkg::ARG_W'(p_wx_r) + qte_pkg::ARG_W'(p_yz_r)) <<< 1;
      rollx_r <= n_nxt - ((qte_pkg::ARG_W'(p_xx_r) + qte_pkg::ARG_W'(p_yy_r)) <<< 1);
      yawy_r  <= (qte_pkg::ARG_W'(p_wz_r) + qte_pkg::ARG_W'(p_xy_r)) <<< 1;
      yawx_r  <= n_nxt - ((qte_pkg::ARG_W'(p_yy_r) + qte_pkg::ARG_W'(p_zz_r)) <<< 1);
      s_r     <= (qte_pkg::ARG_W'(p_wy_r) - qte_pkg::ARG_W'(p_zx_r)) <<< 1;
      degen_r <= n_nxt < qte_pkg::DEGEN_N;
    end
  end

  // Pitch preparation: clamp test and the scaled operands of n^2 - s^2.
  logic signed [qte_pkg::ARG_W-1:0] as_v;
  logic                             clamp_v;
  logic [qte_pkg::SQ_BITS-1:0]      nn_v;
  logic [qte_pkg::SQ_BITS-1:0]      ss_v;
  qte_pkg::side_t                   side3_r;
  logic [qte_pkg::SQ_BITS-1:0]      d_r;
  logic [qte_pkg::SQ_BITS:0]        a_r;

  always_comb begin
    as_v    = s_r[qte_pkg::ARG_W-1] ? -s_r : s_r;
    clamp_v = !degen_r && (as_v >= n_r);
    priority if (n_r[32]) begin
      nn_v = n_r[32:2];
      ss_v = as_v[32:2];
    end else if (n_r[31]) begin
      nn_v = n_r[31:1];
      ss_v = as_v[31:1];
    end else begin
      nn_v = n_r[30:0];
      ss_v = as_v[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r.roll_y    <= rolly_r;
      side3_r.roll_x    <= rollx_r;
      side3_r.yaw_y     <= yawy_r;
      side3_r.yaw_x     <= yawx_r;
      side3_r.ss        <= ss_v;
      side3_r.tag.degen <= degen_r;
      side3_r.tag.clamp <= clamp_v;
      side3_r.tag.neg   <= s_r[qte_pkg::ARG_W-1];
      d_r               <= nn_v - ss_v;
      a_r               <= (qte_pkg::SQ_BITS+1)'(nn_v) + (qte_pkg::SQ_BITS+1)'(ss_v);
    end
  end

  logic [qte_pkg::SQ_VW-1:0] v_r;
  qte_pkg::side_t            side4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r     <= qte_pkg::SQ_VW'(d_r) * qte_pkg::SQ_VW'(a_r);
      side4_r <= side3_r;
    end
  end

  // Square root, one result bit per cell.
  qte_pkg::sq_t sq [qte_pkg::SQ_BITS+1];

  assign sq[0] = '{rem: v_r, root: '0, side: side4_r};

  for (genvar g = 0; g < qte_pkg::SQ_BITS; g++) begin : g_sqrt
    qte_sqrt_cell #(.BIT(qte_pkg::SQ_BITS - 1 - g)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (sq[g]),
      .d_out (sq[g+1])
    );
  end

  // Arguments for the three arctangents.
  logic signed [qte_pkg::ARG_W-1:0] ssx;
  logic signed [qte_pkg::ARG_W-1:0] ry_a_r, rx_a_r, yy_a_r, yx_a_r, py_a_r, px_a_r;
  qte_pkg::tag_t                    tag_a_r;
  qte_pkg::tag_t                    ry_tag;
  qte_pkg::tag_t                    pitch_tag;

  assign ssx = qte_pkg::ARG_W'(sq[qte_pkg::SQ_BITS].side.ss);

  always_ff @(posedge clk) begin
    if (adv) begin
      ry_a_r  <= sq[qte_pkg::SQ_BITS].side.roll_y;
      rx_a_r  <= sq[qte_pkg::SQ_BITS].side.roll_x;
      yy_a_r  <= sq[qte_pkg::SQ_BITS].side.yaw_y;
      yx_a_r  <= sq[qte_pkg::SQ_BITS].side.yaw_x;
      py_a_r  <= sq[qte_pkg::SQ_BITS].side.tag.neg ? -ssx : ssx;
      px_a_r  <= qte_pkg::ARG_W'(sq[qte_pkg::SQ_BITS].root);
      tag_a_r <= sq[qte_pkg::SQ_BITS].side.tag;
    end
  end

  // Roll and yaw only need the degenerate override.
  assign ry_tag = '{degen: tag_a_r.degen, clamp: 1'b0, neg: 1'b0};

  logic signed [15:0] roll_ang;
  logic signed [14:0] pitch_ang;
  logic signed [15:0] yaw_ang;

  qte_atan2 #(.ITERS(ANGLE_ITERATIONS), .OUT_W(16), .LIMIT(18000)) u_roll (
    .clk     (clk),
    .en      (adv),
    .arg_y   (ry_a_r),
    .arg_x   (rx_a_r),
    .tag_in  (ry_tag),
    .angle   (roll_ang),
    .tag_out ()
  );

  qte_atan2 #(.ITERS(ANGLE_ITERATIONS), .OUT_W(15), .LIMIT(9000)) u_pitch (
    .clk     (clk),
    .en      (adv),
    .arg_y   (py_a_r),
    .arg_x   (px_a_r),
    .tag_in  (tag_a_r),
    .angle   (pitch_ang),
    .tag_out (pitch_tag)
  );

  qte_atan2 #(.ITERS(ANGLE_ITERATIONS), .OUT_W(16), .LIMIT(18000)) u_yaw (
    .clk     (clk),
    .en      (adv),
    .arg_y   (yy_a_r),
    .arg_x   (yx_a_r),
    .tag_in  (ry_tag),
    .angle   (yaw_ang),
    .tag_out ()
  );

  assign out_stream.valid          = vld_r[LAT-1];
  assign out_stream.roll_centideg  = roll_ang;
  assign out_stream.pitch_centideg = pitch_ang;
  assign out_stream.yaw_centideg   = yaw_ang;
  assign out_stream.degenerate     = pitch_tag.degen;
  assign out_stream.pitch_clamped  = pitch_tag.clamp;

  // A degenerate beat carries zero angles and no clamp.
  `QTE_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_stream.valid && out_stream.degenerate, out_stream.roll_centideg == 16'sd0 && out_stream.pitch_centideg == 15'sd0 && out_stream.yaw_centideg == 16'sd0 && !out_stream.pitch_clamped)
  `QTE_ASSERT_IMPL(a_clamp_pm90, clk, rst_n, out_stream.valid && out_stream.pitch_clamped, out_stream.pitch_centideg == 15'sd9000 || out_stream.pitch_centideg == -15'sd9000)
  `QTE_ASSERT_IMPL(a_roll_range, clk, rst_n, out_stream.valid, out_stream.roll_centideg <= 16'sd18000 && out_stream.roll_centideg >= -16'sd18000)
  `QTE_ASSERT_NEXT(a_drain, clk, rst_n, out_stream.valid && out_stream.ready && !vld_r[LAT-2], !out_stream.valid)

endmodule
